@@ hw/rtl/dcs_pkg.sv @@
// ----------------------------------------------------------------------------
// dcs_pkg
// Shared types, codes and constants of the drive command sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package dcs_pkg;

    localparam int DUTY_W = 7;
    localparam int TICK_W = 8;
    localparam int ANGLE_W = 7;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 8;

    typedef logic [1:0]        t_kind;
    typedef logic [3:0]        t_cmd;
    typedef logic [2:0]        t_sens;
    typedef logic [2:0]        t_op;
    typedef logic [DUTY_W-1:0] t_duty;
    typedef logic [TICK_W-1:0] t_tick;
    typedef logic [1:0]        t_dir;

    localparam t_kind KIND_TICK   = 2'd0;
    localparam t_kind KIND_CMD    = 2'd1;
    localparam t_kind KIND_SAMPLE = 2'd2;

    localparam t_cmd CMD_STOP       = 4'd0;
    localparam t_cmd CMD_START      = 4'd1;
    localparam t_cmd CMD_BACK       = 4'd2;
    localparam t_cmd CMD_FASTER     = 4'd3;
    localparam t_cmd CMD_SLOWER     = 4'd4;
    localparam t_cmd CMD_PIVOT_L    = 4'd5;
    localparam t_cmd CMD_PIVOT_R    = 4'd6;
    localparam t_cmd CMD_ANGLE_UP   = 4'd7;
    localparam t_cmd CMD_ANGLE_DOWN = 4'd8;
    localparam t_cmd CMD_QUIT       = 4'd9;
    localparam t_cmd CMD_MANUAL     = 4'd10;
    localparam t_cmd CMD_TRACE      = 4'd11;

    localparam t_op OP_FWD   = 3'd0;
    localparam t_op OP_BACK  = 3'd1;
    localparam t_op OP_BRAKE = 3'd2;
    localparam t_op OP_SET   = 3'd3;
    localparam t_op OP_OFF   = 3'd4;

    localparam t_dir DIR_STOP = 2'd0;
    localparam t_dir DIR_FWD  = 2'd1;
    localparam t_dir DIR_BACK = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_FULL_SPEED    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SLOW_SPEED    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_SPEED = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPEED_STEP    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_TICKS_QUARTER = 3'd4;

    localparam int MAX_DUTY        = 100;
    localparam int ANGLE_STEP      = 5;
    localparam int ANGLE_MIN       = 5;
    localparam int ANGLE_MAX       = 90;
    localparam int QUARTER_DEG     = 90;
    localparam int PIV_ROUND       = 89;
    localparam int MIN_PIVOT_TICKS = 3;

    localparam int RST_FULL_SPEED    = 60;
    localparam int RST_SLOW_SPEED    = 20;
    localparam int RST_INITIAL_SPEED = 50;
    localparam int RST_SPEED_STEP    = 5;
    localparam int RST_TICKS_QUARTER = 30;

    localparam int RAMP_STEPS  = 10;
    localparam int QUEUE_DEPTH = 4;

    // angle * ticks + round fits in PIV_N bits; exact divide by 90 via reciprocal
    localparam int PIV_N     = 15;
    localparam int PIV_SHIFT = PIV_N + $clog2(QUARTER_DEG);
    localparam int PIV_RECIP = ((1 << PIV_SHIFT) + QUARTER_DEG - 1) / QUARTER_DEG;
    localparam int PIV_RCP_W = PIV_N + 1;

    typedef struct packed {
        t_duty full_speed;
        t_duty slow_speed;
        t_duty initial_speed;
        t_duty speed_step;
        t_tick ticks_quarter;
    } t_cfg;

    typedef struct packed {
        t_op   lop;
        t_duty lval;
        t_op   rop;
        t_duty rval;
    } t_pair;

    localparam logic JOB_PAIRS = 1'b0;
    localparam logic JOB_RAMP  = 1'b1;

    typedef struct packed {
        logic  mode;
        logic  two;
        t_pair p0;
        t_pair p1;
        t_duty ramp_speed;
        t_op   ramp_op;
    } t_job;

endpackage

`default_nettype wire

@@ hw/rtl/dcs_item_if.sv @@
// ----------------------------------------------------------------------------
// dcs_item_if
// Input request channel: tick, drive command or line sensor sample.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcs_item_if;
    logic          valid;
    logic          ready;
    dcs_pkg::t_kind kind;
    dcs_pkg::t_cmd  command;
    dcs_pkg::t_sens sensors;

    modport source(output valid, output kind, output command, output sensors, input ready);
    modport sink(input valid, input kind, input command, input sensors, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/dcs_res_if.sv @@
// ----------------------------------------------------------------------------
// dcs_res_if
// Result request channel: one left/right motor command pair.
// ----------------------------------------------------------------------------
`default_nettype none

interface dcs_res_if;
    logic           valid;
    logic           ready;
    dcs_pkg::t_op   left_op;
    dcs_pkg::t_duty left_value;
    dcs_pkg::t_op   right_op;
    dcs_pkg::t_duty right_value;
    logic           last;

    modport source(output valid, output left_op, output left_value, output right_op,
                   output right_value, output last, input ready);
    modport sink(input valid, input left_op, input left_value, input right_op,
                 input right_value, input last, output ready);
endinterface

`default_nettype wire

@@ hw/rtl/drive_command_sequencer.sv @@
// ----------------------------------------------------------------------------
// drive_command_sequencer
// Two-motor drive sequencer: requests in, motor command pairs out.
//
//   channel   dir  handshake        payload
//   i_item    in   valid/ready      kind, command, sensors
//   o_res     out  valid/ready      left_op/value, right_op/value, last
//   i_cfg_*   in   write enable     index, data (no read-back)
//
// Front takes one request per cycle; after an angle change, ready drops while
// the pivot length product settles. Back emits one pair per cycle while o_res
// is ready: two for most requests, 2*RAMP_STEPS+4 for a reversal ramp.
// A QUEUE_DEPTH job queue decouples the two; ready drops when it is full.
// Reset is synchronous; the front is not ready in the first cycle after it.
// ----------------------------------------------------------------------------
`default_nettype none

module drive_command_sequencer #(
    parameter int RAMP_STEPS  = dcs_pkg::RAMP_STEPS,
    parameter int QUEUE_DEPTH = dcs_pkg::QUEUE_DEPTH
) (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    dcs_item_if.sink                              i_item,
    dcs_res_if.source                             o_res,
    input  wire logic                             i_cfg_we,
    input  wire logic [dcs_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  wire logic [dcs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    dcs_pkg::t_cfg r_cfg;
    logic          s_push, s_pop, s_full, s_empty, s_halted;
    dcs_pkg::t_job s_push_job, s_q_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.full_speed    <= dcs_pkg::DUTY_W'(dcs_pkg::RST_FULL_SPEED);
            r_cfg.slow_speed    <= dcs_pkg::DUTY_W'(dcs_pkg::RST_SLOW_SPEED);
            r_cfg.initial_speed <= dcs_pkg::DUTY_W'(dcs_pkg::RST_INITIAL_SPEED);
            r_cfg.speed_step    <= dcs_pkg::DUTY_W'(dcs_pkg::RST_SPEED_STEP);
            r_cfg.ticks_quarter <= dcs_pkg::TICK_W'(dcs_pkg::RST_TICKS_QUARTER);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                dcs_pkg::CFG_FULL_SPEED:    r_cfg.full_speed    <= i_cfg_data[6:0];
                dcs_pkg::CFG_SLOW_SPEED:    r_cfg.slow_speed    <= i_cfg_data[6:0];
                dcs_pkg::CFG_INITIAL_SPEED: r_cfg.initial_speed <= i_cfg_data[6:0];
                dcs_pkg::CFG_SPEED_STEP:    r_cfg.speed_step    <= i_cfg_data[6:0];
                dcs_pkg::CFG_TICKS_QUARTER: r_cfg.ticks_quarter <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    dcs_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (i_item),
        .i_cfg    (r_cfg),
        .i_q_full (s_full),
        .o_push   (s_push),
        .o_job    (s_push_job),
        .o_halted (s_halted)
    );

    dcs_queue #(
        .WIDTH ($bits(dcs_pkg::t_job)),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (s_push),
        .i_data  (s_push_job),
        .i_pop   (s_pop),
        .o_data  (s_q_job),
        .o_full  (s_full),
        .o_empty (s_empty)
    );

    dcs_back #(
        .RAMP_STEPS (RAMP_STEPS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (!s_empty),
        .i_q_job   (s_q_job),
        .o_pop     (s_pop),
        .o_res     (o_res)
    );

`ifndef ASSERT_OFF
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_push |-> !s_full)
        else $error("job pushed into full queue");

    a_halted_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_halted |-> !s_push)
        else $error("job created after quit");

    a_value_only_on_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.left_op != dcs_pkg::OP_SET) |-> (o_res.left_value == '0))
        else $error("duty on non set-speed op");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_pop |-> !s_empty)
        else $error("pop from empty queue");
`endif

endmodule

`default_nettype wire

@@ hw/rtl/dcs_queue.sv @@
// ----------------------------------------------------------------------------
// dcs_queue
// Small flip-flop job queue between the front and the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module dcs_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_push,
    input  wire logic [WIDTH-1:0] i_data,
    input  wire logic             i_pop,
    output logic      [WIDTH-1:0] o_data,
    output logic                  o_full,
    output logic                  o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, r_rd;
    logic [CW-1:0]    r_cnt;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

`default_nettype wire

@@ hw/rtl/dcs_front.sv @@
// ----------------------------------------------------------------------------
// dcs_front
// Accepts requests, keeps the drive state and turns requests into jobs where they call for one.
// ----------------------------------------------------------------------------
`default_nettype none

module dcs_front (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    dcs_item_if.sink           i_item,
    input  wire dcs_pkg::t_cfg i_cfg,
    input  wire logic          i_q_full,
    output logic               o_push,
    output dcs_pkg::t_job      o_job,
    output logic               o_halted
);

    localparam int PROD_W = dcs_pkg::ANGLE_W + dcs_pkg::TICK_W;
    localparam int MUL_W  = dcs_pkg::PIV_N + dcs_pkg::PIV_RCP_W;

    function automatic dcs_pkg::t_duty cap_duty(input dcs_pkg::t_duty v);
        return (v > dcs_pkg::DUTY_W'(dcs_pkg::MAX_DUTY)) ?
               dcs_pkg::DUTY_W'(dcs_pkg::MAX_DUTY) : v;
    endfunction

    function automatic dcs_pkg::t_pair mk_pair(input dcs_pkg::t_op lop,
                                               input dcs_pkg::t_duty lval,
                                               input dcs_pkg::t_op rop,
                                               input dcs_pkg::t_duty rval);
        dcs_pkg::t_pair p;
        p.lop  = lop;
        p.lval = lval;
        p.rop  = rop;
        p.rval = rval;
        return p;
    endfunction

    logic                          r_trace_mode, n_trace_mode;
    logic                          r_tracing, n_tracing;
    logic                          r_halted, n_halted;
    dcs_pkg::t_duty                r_speed, n_speed;
    dcs_pkg::t_duty                r_rem, n_rem;
    dcs_pkg::t_dir                 r_dir, n_dir;
    logic [dcs_pkg::ANGLE_W-1:0]   r_angle, n_angle;
    dcs_pkg::t_tick                r_cd, n_cd;
    logic                          r_settle, n_settle;
    logic [PROD_W-1:0]             r_prod;

    logic                          s_accept;
    logic [dcs_pkg::PIV_N-1:0]     s_num;
    logic [MUL_W-1:0]              s_mul;
    logic [MUL_W-1:0]              s_quot;
    dcs_pkg::t_tick                s_ticks;
    dcs_pkg::t_duty                s_fs, s_ss, s_resume;
    logic [dcs_pkg::DUTY_W:0]      s_sum;
    dcs_pkg::t_op                  s_dir_op;
    logic                          s_c, s_l;

    assign i_item.ready = !r_settle && !i_q_full;
    assign s_accept     = i_item.valid && i_item.ready;
    assign o_halted     = r_halted;

    assign s_num  = dcs_pkg::PIV_N'(r_prod) + dcs_pkg::PIV_N'(dcs_pkg::PIV_ROUND);
    assign s_mul  = MUL_W'(s_num) * MUL_W'(dcs_pkg::PIV_RECIP);
    assign s_quot = s_mul >> dcs_pkg::PIV_SHIFT;
    assign s_ticks = (s_quot < MUL_W'(dcs_pkg::MIN_PIVOT_TICKS)) ?
                     dcs_pkg::TICK_W'(dcs_pkg::MIN_PIVOT_TICKS) : s_quot[dcs_pkg::TICK_W-1:0];

    assign s_fs     = cap_duty(i_cfg.full_speed);
    assign s_ss     = cap_duty(i_cfg.slow_speed);
    assign s_resume = (r_rem != '0) ? r_rem : cap_duty(i_cfg.initial_speed);
    assign s_sum    = {1'b0, r_speed} + {1'b0, i_cfg.speed_step};
    assign s_dir_op = (r_dir == dcs_pkg::DIR_FWD) ? dcs_pkg::OP_FWD : dcs_pkg::OP_BACK;
    assign s_c      = i_item.sensors[2];
    assign s_l      = i_item.sensors[1];

    always_comb begin
        n_trace_mode = r_trace_mode;
        n_tracing    = r_tracing;
        n_halted     = r_halted;
        n_speed      = r_speed;
        n_rem        = r_rem;
        n_dir        = r_dir;
        n_angle      = r_angle;
        n_cd         = r_cd;
        n_settle     = 1'b0;
        o_push       = 1'b0;
        o_job        = '0;
        o_job.mode   = dcs_pkg::JOB_PAIRS;

        if (s_accept && !r_halted) begin
            unique case (i_item.kind)
                dcs_pkg::KIND_TICK: begin
                    if (r_cd != '0 && !r_trace_mode) begin
                        n_cd = r_cd - 1'b1;
                        if (r_cd == dcs_pkg::TICK_W'(1) && r_dir != dcs_pkg::DIR_STOP) begin
                            o_push    = 1'b1;
                            o_job.two = 1'b1;
                            o_job.p0  = mk_pair(s_dir_op, '0, s_dir_op, '0);
                            o_job.p1  = mk_pair(dcs_pkg::OP_SET, r_speed,
                                                dcs_pkg::OP_SET, r_speed);
                        end
                    end
                end
                dcs_pkg::KIND_CMD: begin
                    if (i_item.command == dcs_pkg::CMD_STOP ||
                        i_item.command == dcs_pkg::CMD_MANUAL ||
                        i_item.command == dcs_pkg::CMD_TRACE) begin
                        n_cd      = '0;
                        n_tracing = 1'b0;
                        if (i_item.command != dcs_pkg::CMD_STOP || r_speed != '0) begin
                            n_rem = r_speed;
                        end
                        if (i_item.command != dcs_pkg::CMD_STOP) begin
                            n_trace_mode = (i_item.command == dcs_pkg::CMD_TRACE);
                        end
                        n_speed   = '0;
                        n_dir     = dcs_pkg::DIR_STOP;
                        o_push    = 1'b1;
                        o_job.two = 1'b1;
                        o_job.p0  = mk_pair(dcs_pkg::OP_SET, '0, dcs_pkg::OP_SET, '0);
                        o_job.p1  = mk_pair(dcs_pkg::OP_BRAKE, '0, dcs_pkg::OP_BRAKE, '0);
                    end else if (i_item.command == dcs_pkg::CMD_QUIT) begin
                        if (r_trace_mode) begin
                            n_tracing = 1'b0;
                        end else begin
                            n_cd = '0;
                        end
                        n_halted  = 1'b1;
                        o_push    = 1'b1;
                        o_job.two = 1'b1;
                        o_job.p0  = mk_pair(dcs_pkg::OP_SET, '0, dcs_pkg::OP_SET, '0);
                        o_job.p1  = mk_pair(dcs_pkg::OP_OFF, '0, dcs_pkg::OP_OFF, '0);
                    end else if (r_trace_mode) begin
                        if (i_item.command == dcs_pkg::CMD_START) begin
                            n_dir     = dcs_pkg::DIR_FWD;
                            n_tracing = 1'b1;
                            o_push    = 1'b1;
                            o_job.two = 1'b1;
                            o_job.p0  = mk_pair(dcs_pkg::OP_FWD, '0, dcs_pkg::OP_FWD, '0);
                            o_job.p1  = mk_pair(dcs_pkg::OP_SET, s_fs, dcs_pkg::OP_SET, s_fs);
                        end
                    end else begin
                        unique case (i_item.command)
                            dcs_pkg::CMD_START, dcs_pkg::CMD_BACK: begin
                                n_cd   = '0;
                                o_push = 1'b1;
                                if (i_item.command == dcs_pkg::CMD_START) begin
                                    n_dir          = dcs_pkg::DIR_FWD;
                                    o_job.ramp_op  = dcs_pkg::OP_FWD;
                                end else begin
                                    n_dir          = dcs_pkg::DIR_BACK;
                                    o_job.ramp_op  = dcs_pkg::OP_BACK;
                                end
                                if (r_dir != dcs_pkg::DIR_STOP && r_dir != n_dir) begin
                                    o_job.mode       = dcs_pkg::JOB_RAMP;
                                    o_job.ramp_speed = r_speed;
                                end else begin
                                    if (r_speed == '0) begin
                                        n_speed = s_resume;
                                    end
                                    o_job.two = 1'b1;
                                    o_job.p0  = mk_pair(o_job.ramp_op, '0, o_job.ramp_op, '0);
                                    o_job.p1  = mk_pair(dcs_pkg::OP_SET, n_speed,
                                                        dcs_pkg::OP_SET, n_speed);
                                end
                            end
                            dcs_pkg::CMD_FASTER: begin
                                n_speed = (s_sum > (dcs_pkg::DUTY_W + 1)'(dcs_pkg::MAX_DUTY)) ?
                                          dcs_pkg::DUTY_W'(dcs_pkg::MAX_DUTY) :
                                          s_sum[dcs_pkg::DUTY_W-1:0];
                                if (r_dir != dcs_pkg::DIR_STOP) begin
                                    o_push   = 1'b1;
                                    o_job.p0 = mk_pair(dcs_pkg::OP_SET, n_speed,
                                                       dcs_pkg::OP_SET, n_speed);
                                end
                            end
                            dcs_pkg::CMD_SLOWER: begin
                                n_speed  = (r_speed > i_cfg.speed_step) ?
                                           r_speed - i_cfg.speed_step : '0;
                                o_push   = 1'b1;
                                o_job.p0 = mk_pair(dcs_pkg::OP_SET, n_speed,
                                                   dcs_pkg::OP_SET, n_speed);
                                if (n_speed == '0) begin
                                    n_dir = dcs_pkg::DIR_STOP;
                                end
                            end
                            dcs_pkg::CMD_PIVOT_L, dcs_pkg::CMD_PIVOT_R: begin
                                if (r_dir != dcs_pkg::DIR_STOP && r_speed != '0) begin
                                    n_cd      = s_ticks;
                                    o_push    = 1'b1;
                                    o_job.two = 1'b1;
                                    if (i_item.command == dcs_pkg::CMD_PIVOT_L) begin
                                        o_job.p0 = mk_pair(dcs_pkg::OP_BACK, '0,
                                                           dcs_pkg::OP_FWD, '0);
                                    end else begin
                                        o_job.p0 = mk_pair(dcs_pkg::OP_FWD, '0,
                                                           dcs_pkg::OP_BACK, '0);
                                    end
                                    o_job.p1 = mk_pair(dcs_pkg::OP_SET, r_speed,
                                                       dcs_pkg::OP_SET, r_speed);
                                end
                            end
                            dcs_pkg::CMD_ANGLE_UP: begin
                                n_settle = 1'b1;
                                n_angle  = (r_angle >= dcs_pkg::ANGLE_W'(dcs_pkg::ANGLE_MAX -
                                                                          dcs_pkg::ANGLE_STEP)) ?
                                           dcs_pkg::ANGLE_W'(dcs_pkg::ANGLE_MAX) :
                                           r_angle + dcs_pkg::ANGLE_W'(dcs_pkg::ANGLE_STEP);
                            end
                            dcs_pkg::CMD_ANGLE_DOWN: begin
                                n_settle = 1'b1;
                                n_angle  = (r_angle > dcs_pkg::ANGLE_W'(dcs_pkg::ANGLE_MIN +
                                                                         dcs_pkg::ANGLE_STEP)) ?
                                           r_angle - dcs_pkg::ANGLE_W'(dcs_pkg::ANGLE_STEP) :
                                           dcs_pkg::ANGLE_W'(dcs_pkg::ANGLE_MIN);
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                dcs_pkg::KIND_SAMPLE: begin
                    if (r_trace_mode && r_tracing) begin
                        o_push    = 1'b1;
                        o_job.two = 1'b1;
                        o_job.p0  = mk_pair(dcs_pkg::OP_FWD, '0, dcs_pkg::OP_FWD, '0);
                        if (s_c && !s_l) begin
                            o_job.p1 = mk_pair(dcs_pkg::OP_SET, s_fs, dcs_pkg::OP_SET, s_fs);
                        end else if (!s_c && !s_l) begin
                            o_job.p1 = mk_pair(dcs_pkg::OP_SET, s_ss, dcs_pkg::OP_SET, s_fs);
                        end else if (!s_c && s_l) begin
                            o_job.p1 = mk_pair(dcs_pkg::OP_SET, s_fs, dcs_pkg::OP_SET, s_ss);
                        end else begin
                            o_job.p1 = mk_pair(dcs_pkg::OP_SET, s_fs,
                                               dcs_pkg::OP_SET, s_ss >> 1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_trace_mode <= 1'b0;
            r_tracing    <= 1'b0;
            r_halted     <= 1'b0;
            r_speed      <= dcs_pkg::DUTY_W'(dcs_pkg::RST_INITIAL_SPEED);
            r_rem        <= dcs_pkg::DUTY_W'(dcs_pkg::RST_INITIAL_SPEED);
            r_dir        <= dcs_pkg::DIR_STOP;
            r_angle      <= dcs_pkg::ANGLE_W'(dcs_pkg::ANGLE_MIN);
            r_cd         <= '0;
            r_settle     <= 1'b1;
        end else begin
            r_trace_mode <= n_trace_mode;
            r_tracing    <= n_tracing;
            r_halted     <= n_halted;
            r_speed      <= n_speed;
            r_rem        <= n_rem;
            r_dir        <= n_dir;
            r_angle      <= n_angle;
            r_cd         <= n_cd;
            r_settle     <= n_settle;
        end
    end

    // pivot length product; ready drops while it settles after every angle change
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(r_angle) * PROD_W'(i_cfg.ticks_quarter);
    end

endmodule

`default_nettype wire

@@ hw/rtl/dcs_back.sv @@
// ----------------------------------------------------------------------------
// dcs_back
// Expands queued jobs into motor command pairs, one per cycle while o_res is ready, registered out.
// ----------------------------------------------------------------------------
`default_nettype none

module dcs_back #(
    parameter int RAMP_STEPS = dcs_pkg::RAMP_STEPS
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_valid,
    input  wire dcs_pkg::t_job i_q_job,
    output logic               o_pop,
    dcs_res_if.source          o_res
);

    localparam int RAMP_LEN = 2 * RAMP_STEPS + 4;
    localparam int ST_W     = $clog2(RAMP_LEN);
    localparam int ACC_W    = $clog2(dcs_pkg::MAX_DUTY * RAMP_STEPS + 1);
    localparam int SHIFT    = ACC_W + $clog2(RAMP_STEPS);
    localparam int RECIP    = ((1 << SHIFT) + RAMP_STEPS - 1) / RAMP_STEPS;
    localparam int MUL_W    = 2 * ACC_W + 1;

    dcs_pkg::t_job     r_job;
    logic              r_active;
    logic [ST_W-1:0]   r_step;
    logic [ACC_W-1:0]  r_acc;
    logic              r_out_valid;
    dcs_pkg::t_pair    r_out;
    logic              r_out_last;

    logic              s_free, s_produce, s_step_last, s_load;
    logic [MUL_W-1:0]  s_mul, s_quot;
    dcs_pkg::t_duty    s_ramp_val;
    dcs_pkg::t_pair    s_pair;

    assign s_free    = !r_out_valid || o_res.ready;
    assign s_produce = r_active && s_free;
    assign s_step_last = (r_job.mode == dcs_pkg::JOB_RAMP) ?
                         (r_step == ST_W'(RAMP_LEN - 1)) : (r_step == ST_W'(r_job.two));
    assign s_load    = i_q_valid && (!r_active || (s_produce && s_step_last));
    assign o_pop     = s_load;

    assign s_mul      = MUL_W'(r_acc) * MUL_W'(RECIP);
    assign s_quot     = s_mul >> SHIFT;
    assign s_ramp_val = s_quot[dcs_pkg::DUTY_W-1:0];

    always_comb begin
        if (r_job.mode == dcs_pkg::JOB_PAIRS) begin
            s_pair = (r_step == '0) ? r_job.p0 : r_job.p1;
        end else if (r_step == ST_W'(RAMP_STEPS + 1)) begin
            s_pair = '{dcs_pkg::OP_BRAKE, '0, dcs_pkg::OP_BRAKE, '0};
        end else if (r_step == ST_W'(RAMP_STEPS + 2)) begin
            s_pair = '{r_job.ramp_op, '0, r_job.ramp_op, '0};
        end else begin
            s_pair = '{dcs_pkg::OP_SET, s_ramp_val, dcs_pkg::OP_SET, s_ramp_val};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_load) begin
                r_active <= 1'b1;
            end else if (s_produce && s_step_last) begin
                r_active <= 1'b0;
            end
            if (s_produce) begin
                r_out_valid <= 1'b1;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_load) begin
            r_job  <= i_q_job;
            r_step <= '0;
            r_acc  <= ACC_W'(i_q_job.ramp_speed * RAMP_STEPS);
        end else if (s_produce) begin
            r_step <= r_step + 1'b1;
            if (r_step < ST_W'(RAMP_STEPS)) begin
                r_acc <= r_acc - ACC_W'(r_job.ramp_speed);
            end else if (r_step > ST_W'(RAMP_STEPS + 2)) begin
                r_acc <= r_acc + ACC_W'(r_job.ramp_speed);
            end
        end
        if (s_produce) begin
            r_out      <= s_pair;
            r_out_last <= s_step_last;
        end
    end

    assign o_res.valid       = r_out_valid;
    assign o_res.left_op     = r_out.lop;
    assign o_res.left_value  = r_out.lval;
    assign o_res.right_op    = r_out.rop;
    assign o_res.right_value = r_out.rval;
    assign o_res.last        = r_out_last;

endmodule

`default_nettype wire
